// ===== rtl/bpe_pkg.sv =====
// Shared types and constants of the byte port ethernet bridge.
`default_nettype none
package bpe_pkg;

    // Request codes carried in the req_type field.
    localparam logic [2:0] REQ_CTRL_WR  = 3'd0;
    localparam logic [2:0] REQ_CTRL_RD  = 3'd1;
    localparam logic [2:0] REQ_DATA_WR  = 3'd2;
    localparam logic [2:0] REQ_DATA_RD  = 3'd3;
    localparam logic [2:0] REQ_RX_START = 3'd4;
    localparam logic [2:0] REQ_RX_BYTE  = 3'd5;

    // Control bit that reinitializes the link, and the empty read backoff reload.
    localparam int         CTRL_LINK_INIT = 0;
    localparam logic [1:0] BACKOFF_RELOAD = 2'd2;
    localparam int         LEVEL_W        = 13;

    typedef enum logic [1:0] {
        TX_LEN_HI  = 2'd0,
        TX_LEN_LO  = 2'd1,
        TX_PAYLOAD = 2'd2
    } t_tx_phase;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_LEN_LO = 1'b1
    } t_state;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  wdata;
        logic [15:0] rx_length;
    } t_req;

    typedef struct packed {
        logic [7:0]         rdata;
        logic [7:0]         tx_byte;
        logic               tx_valid;
        logic               tx_last;
        logic               tx_abort;
        logic               tx_len_error;
        logic               rx_overflow;
        logic               link_reset;
        logic [LEVEL_W-1:0] queue_level;
    } t_res;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic       clear;
        logic [7:0] wbyte;
    } t_q_cmd;

    typedef struct packed {
        logic [7:0]         rd_byte;
        logic               full;
        logic               empty;
        logic [LEVEL_W-1:0] level;
    } t_q_stat;

    typedef struct packed {
        logic       wr;
        logic       init;
        logic [7:0] wbyte;
    } t_tx_cmd;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       tx_last;
        logic       tx_abort;
        logic       tx_len_error;
    } t_tx_out;

endpackage
`default_nettype wire

// ===== rtl/bpe_queue.sv =====
// Receive byte queue: one synchronous memory with head, tail and fill count.
`default_nettype none
module bpe_queue #(
    parameter int DEPTH = 4096
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire bpe_pkg::t_q_cmd i_cmd,
    output bpe_pkg::t_q_stat     o_stat
);
    localparam int PW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rd;
    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_tail, n_tail;
    logic [FW-1:0] r_fill, n_fill;
    logic          push_ok;
    logic          pop_ok;
    logic          full;
    logic          empty;

    assign full    = (r_fill == FW'(DEPTH));
    assign empty   = (r_fill == '0);
    assign push_ok = i_cmd.push && !full && !i_cmd.clear;
    assign pop_ok  = i_cmd.pop && !empty && !i_cmd.clear;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_fill = r_fill;
        if (i_cmd.clear) begin
            n_head = '0;
            n_tail = '0;
            n_fill = '0;
        end else if (push_ok) begin
            n_tail = (r_tail == PW'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
            n_fill = r_fill + 1'b1;
        end else if (pop_ok) begin
            n_head = (r_head == PW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_tail] <= i_cmd.wbyte;
        end
    end

    // The read port always fetches the next head entry; a byte written to that
    // entry in the same cycle is forwarded so the registered byte is never stale.
    always_ff @(posedge i_clk) begin
        if (push_ok && (r_tail == n_head)) begin
            r_rd <= i_cmd.wbyte;
        end else begin
            r_rd <= r_mem[n_head];
        end
    end

    assign o_stat.rd_byte = r_rd;
    assign o_stat.full    = full;
    assign o_stat.empty   = empty;
    assign o_stat.level   = bpe_pkg::LEVEL_W'(r_fill);

endmodule
`default_nettype wire

// ===== rtl/bpe_tx_framer.sv =====
// Transmit framer: takes a big-endian length, then streams that many payload bytes.
`default_nettype none
module bpe_tx_framer (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire bpe_pkg::t_tx_cmd i_cmd,
    output bpe_pkg::t_tx_out      o_out
);
    bpe_pkg::t_tx_phase r_phase, n_phase;
    logic [15:0]        r_length, n_length;
    logic [15:0]        r_count, n_count;
    logic [15:0]        count_inc;

    assign count_inc = r_count + 16'd1;

    always_comb begin
        n_phase  = r_phase;
        n_length = r_length;
        n_count  = r_count;
        if (i_cmd.init) begin
            n_phase = bpe_pkg::TX_LEN_HI;
            n_count = '0;
        end else if (i_cmd.wr) begin
            unique case (r_phase)
                bpe_pkg::TX_LEN_HI: begin
                    n_length = {i_cmd.wbyte, 8'h00};
                    n_phase  = bpe_pkg::TX_LEN_LO;
                end
                bpe_pkg::TX_LEN_LO: begin
                    n_length = {r_length[15:8], i_cmd.wbyte};
                    n_count  = '0;
                    n_phase  = ({r_length[15:8], i_cmd.wbyte} == 16'd0)
                             ? bpe_pkg::TX_LEN_HI : bpe_pkg::TX_PAYLOAD;
                end
                bpe_pkg::TX_PAYLOAD: begin
                    if (count_inc == r_length) begin
                        n_phase = bpe_pkg::TX_LEN_HI;
                        n_count = '0;
                    end else begin
                        n_count = count_inc;
                    end
                end
                default: begin
                    n_phase = bpe_pkg::TX_LEN_HI;
                end
            endcase
        end
    end

    always_comb begin
        o_out = '0;
        if (i_cmd.init) begin
            o_out.tx_abort = (r_phase != bpe_pkg::TX_LEN_HI);
        end else if (i_cmd.wr) begin
            unique case (r_phase)
                bpe_pkg::TX_LEN_HI: begin
                    o_out = '0;
                end
                bpe_pkg::TX_LEN_LO: begin
                    o_out.tx_len_error = ({r_length[15:8], i_cmd.wbyte} == 16'd0);
                end
                bpe_pkg::TX_PAYLOAD: begin
                    o_out.tx_byte  = i_cmd.wbyte;
                    o_out.tx_valid = 1'b1;
                    o_out.tx_last  = (count_inc == r_length);
                end
                default: begin
                    o_out = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= bpe_pkg::TX_LEN_HI;
            r_length <= '0;
            r_count  <= '0;
        end else begin
            r_phase  <= n_phase;
            r_length <= n_length;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/byte_port_ethernet_bridge.sv =====
// Top level of the byte port ethernet bridge: request decode, control and read backoff.
//
// Requests enter on i_req and are taken at a clock edge where start is high and
// busy is low. Each request yields one result word on o_res, marked by o_strobe
// for exactly one cycle; the receiver cannot hold it off and takes it at the
// edge that ends that cycle.
// A result is registered and shows in the cycle after the request is taken.
// A request can be taken every cycle while busy is low. An rx frame start with a nonzero length
// writes two length bytes through the single write port of the queue memory,
// so it holds busy high while the low byte is written, and its result follows that write.
// The queue memory keeps the byte at the head already read out, so a data read
// completes in its own cycle.
// Reset clears control bits, the transmit framer, the read backoff and the queue
// pointers; the queue memory itself is not cleared and needs no clearing pass.
// queue_level in a result gives the bytes waiting after that request.
`default_nettype none
module byte_port_ethernet_bridge #(
    parameter int QUEUE_DEPTH = 4096
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire bpe_pkg::t_req i_req,
    output logic               busy,
    output logic               o_strobe,
    output bpe_pkg::t_res      o_res
);
    bpe_pkg::t_state  r_state, n_state;
    logic [7:0]       r_ctrl, n_ctrl;
    logic [1:0]       r_backoff, n_backoff;
    logic [7:0]       r_lo_byte, n_lo_byte;
    logic             r_ovf_hi, n_ovf_hi;
    bpe_pkg::t_res    r_res, n_res;
    logic             r_strobe, n_strobe;
    logic             accept;
    logic [7:0]       ctrl_or;
    logic [1:0]       backoff_dec;
    bpe_pkg::t_q_cmd  q_cmd;
    bpe_pkg::t_q_stat q_stat;
    bpe_pkg::t_tx_cmd tx_cmd;
    bpe_pkg::t_tx_out tx_out;

    bpe_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (q_cmd),
        .o_stat (q_stat)
    );

    bpe_tx_framer u_tx (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (tx_cmd),
        .o_out  (tx_out)
    );

    assign accept      = start && !busy;
    assign ctrl_or     = r_ctrl | i_req.wdata;
    assign backoff_dec = (r_backoff != 2'd0) ? r_backoff - 2'd1 : 2'd0;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bpe_pkg::ST_IDLE: begin
                if (accept && (i_req.req_type == bpe_pkg::REQ_RX_START)
                        && (i_req.rx_length != 16'd0)) begin
                    n_state = bpe_pkg::ST_LEN_LO;
                end
            end
            bpe_pkg::ST_LEN_LO: begin
                n_state = bpe_pkg::ST_IDLE;
            end
            default: begin
                n_state = bpe_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        busy = (r_state == bpe_pkg::ST_LEN_LO);
    end

    always_comb begin
        n_ctrl       = r_ctrl;
        n_backoff    = r_backoff;
        n_lo_byte    = r_lo_byte;
        n_ovf_hi     = r_ovf_hi;
        n_res        = '0;
        n_strobe     = 1'b0;
        q_cmd        = '0;
        tx_cmd       = '0;
        tx_cmd.wbyte = i_req.wdata;
        if (r_state == bpe_pkg::ST_LEN_LO) begin
            q_cmd.push        = 1'b1;
            q_cmd.wbyte       = r_lo_byte;
            n_res.rx_overflow = r_ovf_hi | q_stat.full;
            n_strobe          = 1'b1;
        end else if (accept) begin
            n_strobe = 1'b1;
            unique case (i_req.req_type)
                bpe_pkg::REQ_CTRL_WR: begin
                    n_ctrl = ctrl_or;
                    if (ctrl_or[bpe_pkg::CTRL_LINK_INIT]) begin
                        n_ctrl[bpe_pkg::CTRL_LINK_INIT] = 1'b0;
                        tx_cmd.init      = 1'b1;
                        q_cmd.clear      = 1'b1;
                        n_res.link_reset = 1'b1;
                        n_res.tx_abort   = tx_out.tx_abort;
                    end
                end
                bpe_pkg::REQ_CTRL_RD: begin
                    n_res.rdata = r_ctrl;
                end
                bpe_pkg::REQ_DATA_WR: begin
                    tx_cmd.wr          = 1'b1;
                    n_res.tx_byte      = tx_out.tx_byte;
                    n_res.tx_valid     = tx_out.tx_valid;
                    n_res.tx_last      = tx_out.tx_last;
                    n_res.tx_len_error = tx_out.tx_len_error;
                end
                bpe_pkg::REQ_DATA_RD: begin
                    // After an empty read the next read returns zero untouched.
                    if (backoff_dec != 2'd0) begin
                        n_backoff = backoff_dec;
                    end else if (q_stat.empty) begin
                        n_backoff = bpe_pkg::BACKOFF_RELOAD;
                    end else begin
                        n_backoff   = 2'd0;
                        q_cmd.pop   = 1'b1;
                        n_res.rdata = q_stat.rd_byte;
                    end
                end
                bpe_pkg::REQ_RX_START: begin
                    if (i_req.rx_length != 16'd0) begin
                        q_cmd.push  = 1'b1;
                        q_cmd.wbyte = i_req.rx_length[15:8];
                        n_ovf_hi    = q_stat.full;
                        n_lo_byte   = i_req.rx_length[7:0];
                        n_strobe    = 1'b0;
                    end
                end
                bpe_pkg::REQ_RX_BYTE: begin
                    q_cmd.push        = 1'b1;
                    q_cmd.wbyte       = i_req.wdata;
                    n_res.rx_overflow = q_stat.full;
                end
                default: begin
                    n_res = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bpe_pkg::ST_IDLE;
            r_ctrl    <= '0;
            r_backoff <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ctrl    <= n_ctrl;
            r_backoff <= n_backoff;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo_byte <= n_lo_byte;
        r_ovf_hi  <= n_ovf_hi;
        r_res     <= n_res;
    end

    // The queue counters already hold the level left by the request being reported.
    always_comb begin
        o_res             = r_res;
        o_res.queue_level = q_stat.level;
        o_strobe          = r_strobe;
    end

`ifndef NO_ASSERTIONS
    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(start && !busy) || $past(busy)))
        else $error("result word without a request");

    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.tx_last) |-> o_res.tx_valid)
        else $error("tx_last without tx_valid");

    a_reset_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.link_reset) |-> (o_res.queue_level == '0))
        else $error("link reset left bytes in the queue");
`endif

endmodule
`default_nettype wire
